>>> rtl/core/gti_pkg.sv
package gti_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 22;

	// correction table: 1/32 spacing in |x|, 22-bit unsigned fractions
	localparam int TABLE_ENTRIES = 177;
	localparam int TABLE_LAST    = TABLE_ENTRIES - 1;
	localparam int ROM_FRAC      = 22;
	localparam int STEP_LOG2     = 5;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);

	typedef logic [ROM_FRAC-1:0] rom_word_t;
	typedef logic [IDX_W-1:0]    rom_idx_t;

	localparam rom_word_t CORR_ROM [TABLE_ENTRIES] = '{
		22'd0,      22'd63902,  22'd124540, 22'd181923, 22'd236067, 22'd286994,
		22'd334732, 22'd379317, 22'd420787, 22'd459189, 22'd494574, 22'd527000,
		22'd556527, 22'd583222, 22'd607157, 22'd628407, 22'd647050, 22'd663170,
		22'd676853, 22'd688187, 22'd697265, 22'd704180, 22'd709027, 22'd711903,
		22'd712908, 22'd712140, 22'd709698, 22'd705682, 22'd700191, 22'd693325,
		22'd685182, 22'd675858, 22'd665448, 22'd654048, 22'd641748, 22'd628639,
		22'd614807, 22'd600337, 22'd585312, 22'd569811, 22'd553909, 22'd537680,
		22'd521192, 22'd504513, 22'd487705, 22'd470827, 22'd453935, 22'd437081,
		22'd420315, 22'd403680, 22'd387220, 22'd370973, 22'd354973, 22'd339252,
		22'd323839, 22'd308759, 22'd294035, 22'd279687, 22'd265730, 22'd252180,
		22'd239047, 22'd226341, 22'd214068, 22'd202235, 22'd190842, 22'd179892,
		22'd169382, 22'd159312, 22'd149677, 22'd140472, 22'd131690, 22'd123323,
		22'd115365, 22'd107804, 22'd100631, 22'd93836,  22'd87407,  22'd81332,
		22'd75600,  22'd70197,  22'd65113,  22'd60334,  22'd55847,  22'd51640,
		22'd47700,  22'd44016,  22'd40574,  22'd37362,  22'd34370,  22'd31584,
		22'd28995,  22'd26590,  22'd24360,  22'd22294,  22'd20383,  22'd18616,
		22'd16986,  22'd15482,  22'd14097,  22'd12823,  22'd11653,  22'd10578,
		22'd9593,   22'd8691,   22'd7866,   22'd7112,   22'd6423,   22'd5796,
		22'd5225,   22'd4705,   22'd4232,   22'd3804,   22'd3415,   22'd3063,
		22'd2744,   22'd2457,   22'd2197,   22'd1962,   22'd1751,   22'd1561,
		22'd1391,   22'd1237,   22'd1100,   22'd977,    22'd866,    22'd768,
		22'd680,    22'd601,    22'd531,    22'd469,    22'd414,    22'd364,
		22'd321,    22'd282,    22'd248,    22'd217,    22'd191,    22'd167,
		22'd146,    22'd128,    22'd111,    22'd97,     22'd85,     22'd74,
		22'd64,     22'd56,     22'd48,     22'd42,     22'd36,     22'd31,
		22'd27,     22'd23,     22'd20,     22'd17,     22'd15,     22'd13,
		22'd11,     22'd10,     22'd8,      22'd7,      22'd6,      22'd5,
		22'd4,      22'd4,      22'd3,      22'd3,      22'd2,      22'd2,
		22'd2,      22'd1,      22'd1,      22'd1,      22'd1,      22'd1,
		22'd1,      22'd1,      22'd0
	};

	// load enables for the interpolation stages
	typedef struct packed {
		logic ld2;
		logic ld3;
		logic ld4;
	} stage_ctl_t;

	// indexes past the table end read as zero
	function automatic rom_word_t corr_entry(input rom_idx_t idx);
		rom_word_t v;
		v = '0;
		if (idx < IDX_W'(TABLE_ENTRIES)) begin
			v = CORR_ROM[idx];
		end
		return v;
	endfunction

endpackage

>>> rtl/core/gti_if.sv
interface gti_x_if #(
	parameter int DATA_WIDTH = gti_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] x_in;

	modport source(output valid, output x_in, input ready);
	modport sink(input valid, input x_in, output ready);
endinterface

interface gti_y_if #(
	parameter int DATA_WIDTH = gti_pkg::DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] y_out;

	modport source(output valid, output y_out, input ready);
	modport sink(input valid, input y_out, output ready);
endinterface

>>> rtl/core/gti_interp.sv
module gti_interp #(
	parameter int DATA_WIDTH = gti_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = gti_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  gti_pkg::stage_ctl_t        ctl,
	input  logic [DATA_WIDTH-1:0]      pos_s1,
	input  gti_pkg::rom_idx_t          idx_s1,
	input  logic                       byp_s1,
	input  logic [FRAC_BITS-1:0]       w_s1,
	output logic [DATA_WIDTH-1:0]      y_s4
);

	localparam int AW = gti_pkg::ROM_FRAC + FRAC_BITS;
	localparam int PW = 2 * FRAC_BITS + 2;
	localparam int SW = (DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH : FRAC_BITS;

	// stage 2: table reads, aligned to FRAC_BITS, and slope
	logic [AW-1:0]               a_full, b_full;
	logic [FRAC_BITS-1:0]        a_al, b_al;
	logic signed [FRAC_BITS:0]   d_next;

	logic [FRAC_BITS-1:0]        a_s2;
	logic signed [FRAC_BITS:0]   d_s2;
	logic [FRAC_BITS-1:0]        w_s2;
	logic [DATA_WIDTH-1:0]       pos_s2;
	logic                        byp_s2;

	always_comb begin
		a_full = {gti_pkg::corr_entry(idx_s1), {FRAC_BITS{1'b0}}} >> gti_pkg::ROM_FRAC;
		b_full = {gti_pkg::corr_entry(idx_s1 + gti_pkg::IDX_W'(1)), {FRAC_BITS{1'b0}}}
			>> gti_pkg::ROM_FRAC;
		a_al   = a_full[FRAC_BITS-1:0];
		b_al   = b_full[FRAC_BITS-1:0];
		d_next = $signed({1'b0, b_al}) - $signed({1'b0, a_al});
	end

	always_ff @(posedge clk) begin
		if (ctl.ld2) begin
			a_s2   <= a_al;
			d_s2   <= d_next;
			w_s2   <= w_s1;
			pos_s2 <= pos_s1;
			byp_s2 <= byp_s1;
		end
	end

	// stage 3: slope times weight
	logic signed [PW-1:0]        prod_next;
	logic signed [PW-1:0]        prod_s3;
	logic [FRAC_BITS-1:0]        a_s3;
	logic [DATA_WIDTH-1:0]       pos_s3;
	logic                        byp_s3;

	assign prod_next = d_s2 * $signed({1'b0, w_s2});

	always_ff @(posedge clk) begin
		if (ctl.ld3) begin
			prod_s3 <= prod_next;
			a_s3    <= a_s2;
			pos_s3  <= pos_s2;
			byp_s3  <= byp_s2;
		end
	end

	// stage 4: corr = a + floor(slope * w), then relu(x) - corr, or relu(x) as is when bypassed
	logic signed [PW-1:0]        prod_sh;
	logic [FRAC_BITS+1:0]        corr_sum;
	logic [FRAC_BITS-1:0]        corr;
	logic [SW-1:0]               y_wide;
	logic [DATA_WIDTH-1:0]       y_next;

	always_comb begin
		prod_sh  = prod_s3 >>> FRAC_BITS;
		corr_sum = {2'b00, a_s3} + prod_sh[FRAC_BITS+1:0];
		corr     = corr_sum[FRAC_BITS-1:0];
		y_wide   = SW'(pos_s3) - SW'(corr);
		y_next   = byp_s3 ? pos_s3 : y_wide[DATA_WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.ld4) begin
			y_s4 <= y_next;
		end
	end

endmodule

>>> rtl/core/gelu_table_interpolation.sv
// GELU approximation as relu(x) minus a correction read from a 177-entry table spaced 1/32
// apart in |x| and linearly interpolated between neighbors; |x| >= 5.5 returns relu(x) as is.
// Four register stages: magnitude and segment select, table read and slope, slope times
// weight on one multiplier, final subtract into the output register. One element per cycle
// sustained while the output is ready; a stalled output holds the pipeline while empty
// stages still fill.
module gelu_table_interpolation #(
	parameter int DATA_WIDTH = gti_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = gti_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	gti_x_if.sink     din,
	gti_y_if.source   dout
);

	localparam int MW        = DATA_WIDTH - 1;
	localparam int SEG_SHIFT = FRAC_BITS - gti_pkg::STEP_LOG2;
	localparam int EW        = MW + FRAC_BITS;

	// handshake chain: a stage loads when it is empty or its successor moves
	logic v1_q, v2_q, v3_q, v4_q;
	logic rdy1, rdy2, rdy3, rdy4;
	gti_pkg::stage_ctl_t ctl;

	assign rdy4 = !v4_q || dout.ready;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;

	assign ctl.ld2 = rdy2 && v1_q;
	assign ctl.ld3 = rdy3 && v2_q;
	assign ctl.ld4 = rdy4 && v3_q;

	assign din.ready  = rdy1;
	assign dout.valid = v4_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= din.valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
		end
	end

	// stage 1: saturating magnitude, segment index, weight
	logic [DATA_WIDTH-1:0] x_u, x_neg, pos;
	logic [MW-1:0]         mag, seg;
	logic [EW-1:0]         mag_ext;
	logic [FRAC_BITS-1:0]  w;
	logic                  byp;

	always_comb begin
		x_u   = din.x_in;
		x_neg = ~x_u + DATA_WIDTH'(1);
		if (x_u[DATA_WIDTH-1]) begin
			// only the most negative input keeps its sign bit after negation
			mag = x_neg[DATA_WIDTH-1] ? {MW{1'b1}} : x_neg[MW-1:0];
			pos = '0;
		end else begin
			mag = x_u[MW-1:0];
			pos = x_u;
		end
		mag_ext = EW'(mag);
		seg     = mag >> SEG_SHIFT;
		byp     = seg >= MW'(gti_pkg::TABLE_LAST);
		w       = {mag_ext[SEG_SHIFT-1:0], {gti_pkg::STEP_LOG2{1'b0}}};
	end

	logic [DATA_WIDTH-1:0] pos_s1;
	gti_pkg::rom_idx_t     idx_s1;
	logic                  byp_s1;
	logic [FRAC_BITS-1:0]  w_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && din.valid) begin
			pos_s1 <= pos;
			idx_s1 <= seg[gti_pkg::IDX_W-1:0];
			byp_s1 <= byp;
			w_s1   <= w;
		end
	end

	logic [DATA_WIDTH-1:0] y_s4;

	gti_interp #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_interp (
		.clk   (clk),
		.ctl   (ctl),
		.pos_s1(pos_s1),
		.idx_s1(idx_s1),
		.byp_s1(byp_s1),
		.w_s1  (w_s1),
		.y_s4  (y_s4)
	);

	assign dout.y_out = $signed(y_s4);

endmodule

>>> dv/gelu_table_interpolation_checker.sv
`timescale 1ns / 1ps

module gelu_table_interpolation_checker (
	input  logic clk,
	input  logic arst_n,
	gti_x_if     x_ch,
	gti_y_if     y_ch,
	output int   errors,
	output int   pending,
	output int   n_results,
	output int   n_interp,
	output int   n_passthru
);

	localparam int DW        = gti_pkg::DATA_WIDTH_DEF;
	localparam int FB        = gti_pkg::FRAC_BITS_DEF;
	localparam int SEG_SHIFT = FB - gti_pkg::STEP_LOG2;

	typedef logic signed [DW-1:0] word_t;

	typedef struct {
		word_t x;
		word_t y;
	} gelu_expect_t;

	gelu_expect_t gelu_expect_q[$];
	int mism      = 0;
	int results   = 0;
	int interp    = 0;
	int passthru  = 0;

	function automatic logic [63:0] align_entry(input gti_pkg::rom_word_t e);
		logic [63:0] v;
		v = 64'(e);
		if (FB >= gti_pkg::ROM_FRAC) begin
			return v << (FB - gti_pkg::ROM_FRAC);
		end
		return v >> (gti_pkg::ROM_FRAC - FB);
	endfunction

	// relu(x) minus interpolated correction; in_tbl is set when |x| < 5.5
	function automatic word_t gelu_approx(input word_t x, output bit in_tbl);
		logic [DW-1:0] mag;
		logic [DW-1:0] relu;
		logic [63:0]   a;
		logic [63:0]   b;
		logic [63:0]   w;
		logic [63:0]   corr;
		int            seg;
		if (x[DW-1]) begin
			mag = -x;
			// most negative input: magnitude saturates
			if (mag == {1'b1, {(DW-1){1'b0}}}) begin
				mag = mag - 1'b1;
			end
			relu = '0;
		end else begin
			mag  = x;
			relu = x;
		end
		in_tbl = 1'b0;
		if (mag >= (DW'(gti_pkg::TABLE_LAST) << SEG_SHIFT)) begin
			return relu;
		end
		in_tbl = 1'b1;
		seg  = int'(mag >> SEG_SHIFT);
		w    = 64'(mag[SEG_SHIFT-1:0]) << gti_pkg::STEP_LOG2;
		a    = align_entry(gti_pkg::CORR_ROM[seg]);
		b    = align_entry(gti_pkg::CORR_ROM[seg+1]);
		corr = (a * ((64'd1 << FB) - w) + b * w) >> FB;
		return relu - corr[DW-1:0];
	endfunction

	always @(posedge clk) begin
		gelu_expect_t e;
		bit           in_tbl;
		if (arst_n) begin
			if (x_ch.valid && x_ch.ready) begin
				e.x = x_ch.x_in;
				e.y = gelu_approx(x_ch.x_in, in_tbl);
				gelu_expect_q.push_back(e);
				if (in_tbl) begin
					interp++;
				end else begin
					passthru++;
				end
			end
			if (y_ch.valid && y_ch.ready) begin
				results++;
				if (gelu_expect_q.size() == 0) begin
					mism++;
					if (mism <= 10) begin
						$display("%0t: result %0d with none expected: y_out=%h",
							$realtime, results, y_ch.y_out);
					end
				end else begin
					e = gelu_expect_q.pop_front();
					if (y_ch.y_out !== e.y) begin
						mism++;
						if (mism <= 10) begin
							$display("%0t: result %0d x_in=%h: y_out expected %h actual %h",
								$realtime, results, e.x, e.y, y_ch.y_out);
						end
					end
				end
			end
		end
		errors     <= mism;
		pending    <= gelu_expect_q.size();
		n_results  <= results;
		n_interp   <= interp;
		n_passthru <= passthru;
	end

endmodule

>>> dv/gelu_table_interpolation_tb.sv
`timescale 1ns / 1ps

module gelu_table_interpolation_tb;

	localparam int DW          = gti_pkg::DATA_WIDTH_DEF;
	localparam int FB          = gti_pkg::FRAC_BITS_DEF;
	localparam int TLAST       = gti_pkg::TABLE_LAST;
	localparam int SEG_SHIFT   = FB - gti_pkg::STEP_LOG2;
	localparam int TBL_END     = TLAST << SEG_SHIFT;
	localparam int NUM_RANDOM  = 1200;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 150;
	localparam int CYCLE_LIMIT = 200000;

	typedef logic signed [DW-1:0] word_t;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;
	int   n_results;
	int   n_interp;
	int   n_passthru;
	int   cycle_cnt;
	int   n_sent;

	gti_x_if #(.DATA_WIDTH(DW)) x_ch ();
	gti_y_if #(.DATA_WIDTH(DW)) y_ch ();

	gelu_table_interpolation #(
		.DATA_WIDTH(DW),
		.FRAC_BITS (FB)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (x_ch),
		.dout  (y_ch)
	);

	gelu_table_interpolation_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.x_ch      (x_ch),
		.y_ch      (y_ch),
		.errors    (errors),
		.pending   (pending),
		.n_results (n_results),
		.n_interp  (n_interp),
		.n_passthru(n_passthru)
	);

	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// mostly inside the table, some on segment edges, the rest anywhere
	function automatic word_t random_x();
		logic [DW-1:0] mag;
		int            kind;
		kind = $urandom_range(0, 9);
		if (kind < 5) begin
			mag = DW'($urandom_range(0, TBL_END + 4096));
		end else if (kind < 7) begin
			mag = (DW'($urandom_range(0, TLAST)) << SEG_SHIFT)
				+ DW'($urandom_range(0, 4)) - DW'(2);
		end else begin
			return word_t'($urandom);
		end
		return $urandom_range(0, 1) ? word_t'(-mag) : word_t'(mag);
	endfunction

	task automatic offer_x(input word_t v, input bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			x_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		x_ch.valid <= 1'b1;
		x_ch.x_in  <= v;
		do @(posedge clk); while (!x_ch.ready);
		n_sent++;
	endtask

	// sender
	initial begin
		word_t edge_x[$];
		x_ch.valid <= 1'b0;
		x_ch.x_in  <= '0;
		n_sent = 0;
		edge_x = '{
			word_t'(0), word_t'(1), word_t'(-1),
			word_t'(32'h7fff_ffff), word_t'(32'h8000_0000), word_t'(32'h8000_0001),
			word_t'(TBL_END), word_t'(-TBL_END), word_t'(TBL_END - 1),
			word_t'(-(TBL_END - 1)), word_t'(TBL_END + 1), word_t'(-(TBL_END + 1)),
			word_t'((1 << SEG_SHIFT) - 1), word_t'(1 << SEG_SHIFT),
			word_t'(-(1 << SEG_SHIFT)), word_t'(1 << FB),
			word_t'(-(1 << FB)), word_t'(24 << SEG_SHIFT),
			word_t'(-(24 << SEG_SHIFT) - 12345),
			word_t'((175 << SEG_SHIFT) + (1 << SEG_SHIFT) - 1),
			word_t'(-((175 << SEG_SHIFT) + (1 << SEG_SHIFT) - 1)),
			word_t'(32'h5555_5555), word_t'(32'haaaa_aaaa)
		};
		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (edge_x[i]) begin
			offer_x(edge_x[i], 1'b0);
		end
		for (int i = 0; i < NUM_RANDOM; i++) begin
			// every third stretch of 150 items runs back to back
			offer_x(random_x(), (i / 150) % 3 == 1);
		end
		x_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("sent %0d activations, checked %0d results", n_sent, n_results);
		$display("%0d interpolated inside the table, %0d at or past the 5.5 cutoff",
			n_interp, n_passthru);
		if (errors == 0 && pending == 0) begin
			$display("gelu_table_interpolation: match");
		end else begin
			$display("gelu_table_interpolation: mismatch");
		end
		$finish;
	end

	// receiver
	initial begin
		int  stall;
		int  rx_count;
		bit  held;
		rx_count = 0;
		held     = 1'b0;
		y_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// one long hold-off so the pipeline backs up into the input
			if (!held && rx_count == HOLD_AT) begin
				held = 1'b1;
				y_ch.ready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
			end
			stall = ((rx_count / 100) % 3 == 1) ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				y_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			y_ch.ready <= 1'b1;
			do @(posedge clk); while (!y_ch.valid);
			rx_count++;
		end
	end

	// watchdog
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d results still due", cycle_cnt, pending);
		$display("gelu_table_interpolation: mismatch");
		$finish;
	end

endmodule
